@@ hw/rtl/dd_odom_pkg.sv @@
// Shared widths, constants, types and the arctangent table of the odometry integrator.
package dd_odom_pkg;

    localparam int SPEED_W    = 16;
    localparam int SUM_W      = 17;
    localparam int GAIN_W     = 18;
    localparam int POS_W      = 32;
    localparam int HEAD_W     = 16;
    localparam int ANG_W      = 18;
    localparam int TRIG_W     = 19;
    localparam int Z_W        = 20;
    localparam int MUL_W      = 19;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int P_W        = 35;
    localparam int P_LO_W     = 17;
    localparam int DH_W       = 25;
    localparam int NH_W       = 27;
    localparam int ACC_W      = 54;
    localparam int DX_W       = ACC_W - 24;
    localparam int PSUM_W     = POS_W + 2;
    localparam int CORDIC_N   = 16;
    localparam int ITER_W     = $clog2(CORDIC_N);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = CFG_IDX_W'(2);

    localparam logic [GAIN_W-1:0] DIST_GAIN_RST    = GAIN_W'(11111);
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST    = GAIN_W'(27778);
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = GAIN_W'(81920);

    // Heading wrap at 3.14 rad in Q3.13, span 6.28 rad
    localparam int WRAP_LIM  = 25723;
    localparam int WRAP_SPAN = 51446;
    localparam int HEAD_MAX  = 32767;
    localparam int HEAD_MIN  = -32768;
    localparam int ANG_LIM   = 81920;

    localparam logic signed [PSUM_W-1:0] POS_MAX = PSUM_W'(64'sd2147483647);
    localparam logic signed [PSUM_W-1:0] POS_MIN = PSUM_W'(-64'sd2147483648);

    // CORDIC constants in Q.16
    localparam logic signed [Z_W-1:0]    HALF_PI_Q16     = Z_W'(102944);
    localparam logic signed [Z_W-1:0]    NEG_HALF_PI_Q16 = -Z_W'(102944);
    localparam logic signed [Z_W-1:0]    PI_Q16          = Z_W'(205887);
    localparam logic signed [TRIG_W-1:0] CORDIC_K        = TRIG_W'(39796);

    typedef struct packed {
        logic                     valid;
        logic signed [TRIG_W-1:0] cos_q16;
        logic signed [TRIG_W-1:0] sin_q16;
    } trig_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            4'd0:    r = Z_W'(51472);
            4'd1:    r = Z_W'(30386);
            4'd2:    r = Z_W'(16055);
            4'd3:    r = Z_W'(8150);
            4'd4:    r = Z_W'(4091);
            4'd5:    r = Z_W'(2047);
            4'd6:    r = Z_W'(1024);
            4'd7:    r = Z_W'(512);
            4'd8:    r = Z_W'(256);
            4'd9:    r = Z_W'(128);
            4'd10:   r = Z_W'(64);
            4'd11:   r = Z_W'(32);
            4'd12:   r = Z_W'(16);
            4'd13:   r = Z_W'(8);
            4'd14:   r = Z_W'(4);
            4'd15:   r = Z_W'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/dd_odom_mul.sv @@
// Shared signed 19x19 multiplier with a registered product.
module dd_odom_mul
    import dd_odom_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] mul_q
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign mul_q = prod_reg;

endmodule

@@ hw/rtl/dd_odom_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of the heading in Q.16.
module dd_odom_cordic
    import dd_odom_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [HEAD_W-1:0] angle,
    output trig_t                    trig
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic                     neg_reg;
    logic signed [TRIG_W-1:0] x_reg;
    logic signed [TRIG_W-1:0] y_reg;
    logic signed [Z_W-1:0]    z_reg;

    logic signed [Z_W-1:0]    z_start;
    logic signed [Z_W-1:0]    z_fold;
    logic                     neg_fold;
    logic signed [TRIG_W-1:0] x_shr;
    logic signed [TRIG_W-1:0] y_shr;
    logic signed [TRIG_W-1:0] x_next;
    logic signed [TRIG_W-1:0] y_next;
    logic signed [Z_W-1:0]    z_next;
    logic signed [Z_W-1:0]    atan_i;

    // Heading in Q3.13 times eight gives Q.16; fold into the right half plane
    always_comb begin
        z_start  = $signed({angle[HEAD_W-1], angle, 3'b000});
        z_fold   = z_start;
        neg_fold = 1'b0;
        if (z_start > HALF_PI_Q16) begin
            z_fold   = z_start - PI_Q16;
            neg_fold = 1'b1;
        end else if (z_start < NEG_HALF_PI_Q16) begin
            z_fold   = z_start + PI_Q16;
            neg_fold = 1'b1;
        end
    end

    always_comb begin
        x_shr  = x_reg >>> iter_reg;
        y_shr  = y_reg >>> iter_reg;
        atan_i = atan_q16(iter_reg);
        if (!z_reg[Z_W-1]) begin
            x_next = x_reg - y_shr;
            y_next = y_reg + x_shr;
            z_next = z_reg - atan_i;
        end else begin
            x_next = x_reg + y_shr;
            y_next = y_reg - x_shr;
            z_next = z_reg + atan_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_N - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= CORDIC_K;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign trig.valid   = done_reg;
    assign trig.cos_q16 = neg_reg ? -x_reg : x_reg;
    assign trig.sin_q16 = neg_reg ? -y_reg : y_reg;

endmodule

@@ hw/rtl/diff_drive_odometry_integrator.sv @@
// Top level of the differential-drive odometry integrator: sequencer, pose state and ports.
//
// Dead-reckoning pose integrator for a two-wheel robot. Each accepted transaction of left and
// right wheel speeds (Q8.8) moves the pose along the heading held before the update and turns
// the heading; the result carries x and y (Q16.16, saturating), the wrapped heading (Q3.13),
// the linear speed and the angular speed. One item occupies the block from acceptance until its
// result is committed; no new item is accepted before then. The work is the 16 iterations of
// the CORDIC sine/cosine unit followed by four passes through the single shared 19x19 multiplier
// for the split position products. A finished result waits in the output stage while the next
// item is taken and worked on; the pose is committed only once the previous result has been
// taken. Gains are written through the cfg_ port, which is always ready; only the low 18 bits
// of the data are kept and writes to unknown indexes are dropped.
module diff_drive_odometry_integrator
    import dd_odom_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SPEED_W-1:0]  s_left_speed,
    input  logic signed [SPEED_W-1:0]  s_right_speed,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_W-1:0]    m_pos_x,
    output logic signed [POS_W-1:0]    m_pos_y,
    output logic signed [HEAD_W-1:0]   m_heading,
    output logic signed [SPEED_W-1:0]  m_linear_speed,
    output logic signed [ANG_W-1:0]    m_angular_speed
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_P      = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_TURN   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ANG    = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_HEAD   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_COS_LO = STEP_W'(16);
    localparam logic [STEP_W-1:0] STEP_COS_HI = STEP_W'(17);
    localparam logic [STEP_W-1:0] STEP_SIN_LO = STEP_W'(18);
    localparam logic [STEP_W-1:0] STEP_SIN_HI = STEP_W'(19);
    localparam logic [STEP_W-1:0] STEP_Y_ACC  = STEP_W'(20);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(21);

    logic [1:0]               state_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     m_valid_reg;

    logic [GAIN_W-1:0]        dist_gain_reg;
    logic [GAIN_W-1:0]        turn_gain_reg;
    logic [GAIN_W-1:0]        angular_gain_reg;

    logic signed [POS_W-1:0]  x_acc_reg;
    logic signed [POS_W-1:0]  y_acc_reg;
    logic signed [HEAD_W-1:0] heading_acc_reg;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   diff_reg;
    logic signed [SPEED_W-1:0] lin_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [DH_W-1:0]    dh_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic signed [HEAD_W-1:0]  head_new_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [POS_W-1:0]   x_new_reg;
    logic signed [POS_W-1:0]   y_new_reg;
    logic signed [SPEED_W-1:0] m_lin_reg;
    logic signed [ANG_W-1:0]   m_ang_reg;

    logic                      in_acc;
    logic                      commit;
    logic signed [SUM_W-1:0]   sum_in;
    logic signed [SUM_W-1:0]   diff_in;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_q;
    trig_t                     trig;

    logic signed [PROD_W:0]    neg_turn;
    logic signed [PROD_W-16-1:0] ang_shr;
    logic signed [ANG_W-1:0]   ang_next;
    logic signed [NH_W-1:0]    nh_raw;
    logic signed [NH_W-1:0]    nh_wrap;
    logic signed [HEAD_W-1:0]  head_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [POS_W-1:0]   pos_base;
    logic signed [PSUM_W-1:0]  pos_sum;
    logic signed [POS_W-1:0]   pos_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign commit    = (state_reg == ST_WRITE) && (!m_valid_reg || m_ready);

    assign sum_in  = SUM_W'(s_right_speed) + SUM_W'(s_left_speed);
    assign diff_in = SUM_W'(s_right_speed) - SUM_W'(s_left_speed);

    dd_odom_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_acc),
        .angle   (heading_acc_reg),
        .trig    (trig)
    );

    dd_odom_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_q (mul_q)
    );

    // Operand schedule for the shared multiplier, whose product is registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_P: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = $signed({1'b0, dist_gain_reg});
            end
            STEP_TURN: begin
                mul_a = MUL_W'(diff_reg);
                mul_b = $signed({1'b0, turn_gain_reg});
            end
            STEP_ANG: begin
                mul_a = MUL_W'(diff_reg);
                mul_b = $signed({1'b0, angular_gain_reg});
            end
            STEP_COS_LO: begin
                mul_a = $signed({2'b00, p_reg[P_LO_W-1:0]});
                mul_b = trig.cos_q16;
            end
            STEP_COS_HI: begin
                mul_a = MUL_W'($signed(p_reg[P_W-1:P_LO_W]));
                mul_b = trig.cos_q16;
            end
            STEP_SIN_LO: begin
                mul_a = $signed({2'b00, p_reg[P_LO_W-1:0]});
                mul_b = trig.sin_q16;
            end
            STEP_SIN_HI: begin
                mul_a = MUL_W'($signed(p_reg[P_W-1:P_LO_W]));
                mul_b = trig.sin_q16;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Angular speed: drop 16 fraction bits, clamp to the reported range
    always_comb begin
        ang_shr = mul_q[PROD_W-1:16];
        if (ang_shr > ANG_LIM) begin
            ang_next = ANG_W'(ANG_LIM);
        end else if (ang_shr < -ANG_LIM) begin
            ang_next = -ANG_W'(ANG_LIM);
        end else begin
            ang_next = ang_shr[ANG_W-1:0];
        end
    end

    assign neg_turn = -((PROD_W + 1)'(mul_q));

    // Heading: add the turn, wrap once, then saturate
    always_comb begin
        nh_raw  = NH_W'(heading_acc_reg) + NH_W'(dh_reg);
        nh_wrap = nh_raw;
        if (nh_raw > WRAP_LIM) begin
            nh_wrap = nh_raw - NH_W'(WRAP_SPAN);
        end else if (nh_raw < -WRAP_LIM) begin
            nh_wrap = nh_raw + NH_W'(WRAP_SPAN);
        end
        if (nh_wrap > HEAD_MAX) begin
            head_next = HEAD_W'(HEAD_MAX);
        end else if (nh_wrap < HEAD_MIN) begin
            head_next = HEAD_W'(HEAD_MIN);
        end else begin
            head_next = nh_wrap[HEAD_W-1:0];
        end
    end

    // One adder and clamp serves x then y
    always_comb begin
        prod_ext = ACC_W'(mul_q);
        pos_base = (step_reg == STEP_SIN_HI) ? x_acc_reg : y_acc_reg;
        pos_sum  = PSUM_W'(pos_base) + PSUM_W'($signed(acc_reg[ACC_W-1:24]));
        if (pos_sum > POS_MAX) begin
            pos_next = POS_MAX[POS_W-1:0];
        end else if (pos_sum < POS_MIN) begin
            pos_next = POS_MIN[POS_W-1:0];
        end else begin
            pos_next = pos_sum[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            sum_reg  <= sum_in;
            diff_reg <= diff_in;
            lin_reg  <= sum_in[SUM_W-1:1];
        end
        if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_TURN:   p_reg        <= mul_q[P_W-1:0];
                STEP_ANG:    dh_reg       <= neg_turn[DH_W+11-1:11];
                STEP_HEAD: begin
                    ang_reg      <= ang_next;
                    head_new_reg <= head_next;
                end
                STEP_COS_HI: acc_reg      <= prod_ext;
                STEP_SIN_LO: acc_reg      <= acc_reg + (prod_ext <<< P_LO_W);
                STEP_SIN_HI: begin
                    acc_reg   <= prod_ext;
                    x_new_reg <= pos_next;
                end
                STEP_Y_ACC:  acc_reg      <= acc_reg + (prod_ext <<< P_LO_W);
                STEP_LAST:   y_new_reg    <= pos_next;
                default:     ;
            endcase
        end
        if (commit) begin
            m_lin_reg <= lin_reg;
            m_ang_reg <= ang_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
            dist_gain_reg    <= DIST_GAIN_RST;
            turn_gain_reg    <= TURN_GAIN_RST;
            angular_gain_reg <= ANGULAR_GAIN_RST;
            x_acc_reg        <= '0;
            y_acc_reg        <= '0;
            heading_acc_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DIST_GAIN:    dist_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_TURN_GAIN:    turn_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_ANGULAR_GAIN: angular_gain_reg <= cfg_data[GAIN_W-1:0];
                    default:          ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                    end
                end
                ST_RUN: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    // hold until the previous result has been taken
                    if (commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (commit) begin
                m_valid_reg     <= 1'b1;
                x_acc_reg       <= x_new_reg;
                y_acc_reg       <= y_new_reg;
                heading_acc_reg <= head_new_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = x_acc_reg;
    assign m_pos_y         = y_acc_reg;
    assign m_heading       = heading_acc_reg;
    assign m_linear_speed  = m_lin_reg;
    assign m_angular_speed = m_ang_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input taken while an item is still being worked on");

    a_trig_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg == STEP_COS_LO) |-> trig.valid)
        else $error("position products started before sine and cosine were ready");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("committed pose not presented as a result");

    a_pose_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> ($stable(x_acc_reg) && $stable(y_acc_reg) && $stable(heading_acc_reg)))
        else $error("pose state changed outside a commit");

endmodule

@@ test/diff_drive_odometry_integrator_tb.sv @@
// Self-checking testbench for the odometry integrator: handshake stimulus, pose prediction, result check.
`timescale 1ns / 1ps

module diff_drive_odometry_integrator_tb;
    import dd_odom_pkg::*;

    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_SPACING    = 600;
    localparam int QUIET_LIMIT     = 3000;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 284;
    localparam int ZERO_GAIN_ITEMS = 30;
    localparam int REPORT_LIMIT    = 10;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(15);

    localparam int ARCTAN_Q16 [CORDIC_N] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [SPEED_W-1:0] vl;
        logic signed [SPEED_W-1:0] vr;
    } wheel_pair_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [HEAD_W-1:0]  heading;
        logic signed [SPEED_W-1:0] linear;
        logic signed [ANG_W-1:0]   angular;
    } pose_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SLOW} ready_mode_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index       = '0;
    logic [CFG_DATA_W-1:0]      cfg_data        = '0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic signed [SPEED_W-1:0]  s_left_speed    = '0;
    logic signed [SPEED_W-1:0]  s_right_speed   = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic signed [POS_W-1:0]    m_pos_x;
    logic signed [POS_W-1:0]    m_pos_y;
    logic signed [HEAD_W-1:0]   m_heading;
    logic signed [SPEED_W-1:0]  m_linear_speed;
    logic signed [ANG_W-1:0]    m_angular_speed;

    // Predicted pose and gains
    int                         est_x           = 0;
    int                         est_y           = 0;
    logic signed [HEAD_W-1:0]   est_heading     = '0;
    logic [GAIN_W-1:0]          dist_gain_cfg   = DIST_GAIN_RST;
    logic [GAIN_W-1:0]          turn_gain_cfg   = TURN_GAIN_RST;
    logic [GAIN_W-1:0]          angular_gain_cfg = ANGULAR_GAIN_RST;

    wheel_pair_t                wheel_queue[$];
    pose_t                      pose_expect[$];
    int                         queued_items    = 0;
    int                         accepted_items  = 0;
    int                         results_seen    = 0;
    int                         fail_count      = 0;
    int                         burst_left      = 0;
    int                         gap_left        = 0;
    int                         hold_left       = 0;
    int                         next_hold_at    = 150;
    logic [8:0]                 rx_cycle        = '0;
    int                         quiet_cycles    = 0;

    diff_drive_odometry_integrator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_speed    (s_left_speed),
        .s_right_speed   (s_right_speed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_heading       (m_heading),
        .m_linear_speed  (m_linear_speed),
        .m_angular_speed (m_angular_speed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Dead-reckon one step on the predicted pose and return the expected result
    function automatic pose_t advance_pose(input logic signed [SPEED_W-1:0] vl,
                                           input logic signed [SPEED_W-1:0] vr);
        longint sum, diff, z, cx, cy, nx, p, nh, ang;
        bit     flip;
        int     i;
        pose_t  r;
        sum  = longint'(vr) + longint'(vl);
        diff = longint'(vr) - longint'(vl);
        ang  = clamp((diff * longint'(angular_gain_cfg)) >>> 16, -ANG_LIM, ANG_LIM);

        // Rotation-mode CORDIC on the heading held before this step
        z    = longint'(est_heading) * 8;
        cx   = longint'(CORDIC_K);
        cy   = 0;
        flip = 1'b0;
        if (z > longint'(HALF_PI_Q16)) begin
            z    = z - longint'(PI_Q16);
            flip = 1'b1;
        end else if (z < -longint'(HALF_PI_Q16)) begin
            z    = z + longint'(PI_Q16);
            flip = 1'b1;
        end
        for (i = 0; i < CORDIC_N; i++) begin
            if (z >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - ARCTAN_Q16[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + ARCTAN_Q16[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end

        p     = sum * longint'(dist_gain_cfg);
        est_x = int'(clamp(longint'(est_x) + ((p * cx) >>> 24), -64'sd2147483648, 64'sd2147483647));
        est_y = int'(clamp(longint'(est_y) + ((p * cy) >>> 24), -64'sd2147483648, 64'sd2147483647));

        nh = longint'(est_heading) + ((-(diff * longint'(turn_gain_cfg))) >>> 11);
        if (nh > WRAP_LIM)
            nh = nh - WRAP_SPAN;
        else if (nh < -WRAP_LIM)
            nh = nh + WRAP_SPAN;
        est_heading = HEAD_W'(clamp(nh, HEAD_MIN, HEAD_MAX));

        r.pos_x   = est_x;
        r.pos_y   = est_y;
        r.heading = est_heading;
        r.linear  = SPEED_W'(sum >>> 1);
        r.angular = ANG_W'(ang);
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_speed();
        case ($urandom_range(0, 9))
            0:       return SPEED_W'($urandom);
            1, 2:    return SPEED_W'(int'($urandom_range(0, 16383)) - 8192);
            default: return SPEED_W'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_gain_word();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 9))
            0:       g = '0;
            1:       g = '1;
            2:       g = GAIN_W'($urandom);
            default: g = GAIN_W'($urandom_range(1, 65535));
        endcase
        // junk in the upper bits must be dropped
        return {(CFG_DATA_W - GAIN_W)'($urandom), g};
    endfunction

    task automatic queue_pair(input logic signed [SPEED_W-1:0] vl,
                              input logic signed [SPEED_W-1:0] vr);
        wheel_queue.push_back('{vl: vl, vr: vr});
        queued_items++;
    endtask

    task automatic queue_random(input int count);
        logic signed [SPEED_W-1:0] a;
        repeat (count) begin
            a = random_speed();
            case ($urandom_range(0, 9))
                0:       queue_pair(a, a);
                1:       queue_pair(a, -a);
                default: queue_pair(a, random_speed());
            endcase
        end
    endtask

    // Call at a rising edge; returns at a rising edge with the channel idle
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DIST_GAIN:    dist_gain_cfg    = data[GAIN_W-1:0];
            REG_TURN_GAIN:    turn_gain_cfg    = data[GAIN_W-1:0];
            REG_ANGULAR_GAIN: angular_gain_cfg = data[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Wait for every queued transaction to be accepted and answered, then let the block go quiet
    task automatic settle();
        do @(posedge aclk); while (accepted_items != queued_items || pose_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t result %0d %s: expected %0d, got %0d",
                         $time, results_seen, name, want, got);
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset gains: extremes, bit patterns, saturating turns and both heading wraps
        queue_pair(0, 0);
        queue_pair(32767, 32767);
        queue_pair(-32768, -32768);
        queue_pair(1, -1);
        queue_pair(-1, 1);
        queue_pair(SPEED_W'(16'h5555), SPEED_W'(16'hAAAA));
        queue_pair(SPEED_W'(16'hAAAA), SPEED_W'(16'h5555));
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        queue_pair(0, 1000);
        repeat (3) queue_pair(1000, 0);
        queue_pair(0, 0);
        settle();

        // Top distance and angular gains and a small turn gain through wide words, and writes that must be dropped
        write_gain(REG_DIST_GAIN, 32'hFFFF_FFFF);
        write_gain(REG_TURN_GAIN, 32'h1234_0100);
        write_gain(REG_ANGULAR_GAIN, 32'hFFFF_FFFF);
        write_gain(REG_UNUSED_LO, '0);
        write_gain(REG_UNUSED_HI, '0);
        repeat (2) queue_pair(32767, 32767);
        repeat (3) queue_pair(-32768, -32768);
        queue_pair(-32768, 32767);
        queue_pair(32767, -32768);
        settle();

        write_gain(REG_DIST_GAIN, '0);
        write_gain(REG_TURN_GAIN, '0);
        write_gain(REG_ANGULAR_GAIN, '0);
        queue_random(ZERO_GAIN_ITEMS);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                write_gain(REG_DIST_GAIN, CFG_DATA_W'(DIST_GAIN_RST));
                write_gain(REG_TURN_GAIN, CFG_DATA_W'(TURN_GAIN_RST));
                write_gain(REG_ANGULAR_GAIN, CFG_DATA_W'(ANGULAR_GAIN_RST));
            end else begin
                write_gain(REG_DIST_GAIN, random_gain_word());
                write_gain(REG_TURN_GAIN, random_gain_word());
                write_gain(REG_ANGULAR_GAIN, random_gain_word());
                write_gain(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                           CFG_DATA_W'($urandom));
            end
            queue_random(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin : wheel_driver
        wheel_pair_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pose_expect.push_back(advance_pose(s_left_speed, s_right_speed));
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (wheel_queue.size() != 0) begin
                    item = wheel_queue.pop_front();
                    s_left_speed  <= item.vl;
                    s_right_speed <= item.vr;
                    s_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotating stall pattern, with a long hold-off now and then to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
            m_ready      <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1'b1;
            case (ready_mode_t'(rx_cycle[8:7]))
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_ready <= (rx_cycle[2:0] != 3'b000) && (rx_cycle[2:0] != 3'b101);
                default:    m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Outputs are stable at the falling edge, so sample there the transaction of the next rise
    always @(negedge aclk) begin : result_check
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pose_expect.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t unexpected result: x=%0d y=%0d heading=%0d", $time,
                             m_pos_x, m_pos_y, m_heading);
            end else begin
                want = pose_expect.pop_front();
                check_field("pos_x", want.pos_x, m_pos_x);
                check_field("pos_y", want.pos_y, m_pos_y);
                check_field("heading", want.heading, m_heading);
                check_field("linear_speed", want.linear, m_linear_speed);
                check_field("angular_speed", want.angular, m_angular_speed);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

@@ sim.f @@
hw/rtl/dd_odom_pkg.sv
hw/rtl/dd_odom_mul.sv
hw/rtl/dd_odom_cordic.sv
hw/rtl/diff_drive_odometry_integrator.sv
test/diff_drive_odometry_integrator_tb.sv
